[rtl/plm_pkg.sv]
// Shared types and constants for the partial envelope and LFO modulator.
// No dependencies.
package plm_pkg;

  typedef logic [1:0] stage_t;

  localparam stage_t STG_ATTACK  = 2'd0;
  localparam stage_t STG_DECAY   = 2'd1;
  localparam stage_t STG_SUSTAIN = 2'd2;
  localparam stage_t STG_RELEASE = 2'd3;

  localparam logic [2:0] CFG_ATTACK_STEP   = 3'd0;
  localparam logic [2:0] CFG_DECAY_STEP    = 3'd1;
  localparam logic [2:0] CFG_RELEASE_STEP  = 3'd2;
  localparam logic [2:0] CFG_SUSTAIN_LEVEL = 3'd3;
  localparam logic [2:0] CFG_PHASE_STEP    = 3'd4;
  localparam logic [2:0] CFG_LFO_DEPTH     = 3'd5;
  localparam logic [2:0] CFG_PER_PARTIAL   = 3'd6;

  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [16:0] attack_step;
    logic [16:0] decay_step;
    logic [16:0] rel_step;
    logic [16:0] sustain_level;
    logic [15:0] phase_step;
    logic [15:0] lfo_depth;
    logic        per_partial;
  } cfg_t;

  // Request leaving the envelope stage towards the modulation pipeline
  typedef struct packed {
    logic        valid;
    logic [15:0] amp;
    logic [16:0] lvl;
    stage_t      stage;
    logic        mod_en;
    logic [15:0] phase;
  } item_t;

endpackage

[rtl/plm_sine_rom.sv]
// Sine table with registered read, built at elaboration from a ninth-order
// odd polynomial of the quarter wave. Depends on nothing outside this file.
module plm_sine_rom #(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [15:0] phase_i,
  output logic        neg_o,
  output logic [14:0] mag_o
);

  localparam int IW = (SINE_ENTRIES > 1) ? $clog2(SINE_ENTRIES) : 1;

  typedef logic [15:0] rom_t [SINE_ENTRIES];

  function automatic logic [14:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x2 = x * x * 64'd4;
    t  = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    t  = 64'd85569306 - ((x2 * t) >> 30);
    t  = 64'd693598668 - ((x2 * t) >> 30);
    t  = 64'd1686629713 - ((x2 * t) >> 30);
    s  = (x * t) >> 29;
    return (s > 64'd32767) ? 15'h7fff : s[14:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] p;
    logic [63:0] x;
    logic [1:0]  quad;
    for (int i = 0; i < SINE_ENTRIES; i++) begin
      p    = (64'(i) * 64'd65536) / SINE_ENTRIES;
      quad = p[15:14];
      x    = quad[0] ? (64'd16384 - {50'd0, p[13:0]}) : {50'd0, p[13:0]};
      r[i] = {quad[1], quarter_sine(x)};
    end
    return r;
  endfunction

  localparam rom_t ROM = build_rom();

  logic [28:0]   idx_full;
  logic [IW-1:0] idx;
  logic [15:0]   data_q;

  assign idx_full = {13'd0, phase_i} * 29'(SINE_ENTRIES);
  assign idx      = idx_full[16 +: IW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= ROM[idx];
    end
  end

  assign neg_o = data_q[15];
  assign mag_o = data_q[14:0];

endmodule

[rtl/plm_state.sv]
// Per-partial state memories (envelope and LFO phase), reset clearing sweep,
// read-modify-write with forwarding and the envelope update. Uses plm_pkg.
module plm_state
  import plm_pkg::*;
#(
  parameter int PARTIALS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  partial_index_i,
  input  logic        is_active_i,
  input  logic [15:0] amplitude_in_i,
  input  logic        block_start_i,
  input  logic        block_any_active_i,
  input  logic        ready_i,
  output item_t       item_o
);

  localparam int AW = (PARTIALS > 1) ? $clog2(PARTIALS) : 1;

  logic [18:0] env_mem [PARTIALS];
  logic [15:0] ph_mem  [PARTIALS];

  logic          clr_q, clr_d;
  logic [AW-1:0] clr_cnt_q, clr_cnt_d;
  logic          all_rel_q, all_rel_d;

  logic          s1_v_q, s1_v_d;
  logic [AW-1:0] s1_addr_q;
  logic          s1_active_q, s1_start_q, s1_any_q, s1_inrange_q;
  logic [15:0]   s1_amp_q;

  logic [18:0]   env_rd_q, fwd_env_data_q;
  logic [15:0]   ph_rd_q, fwd_ph_data_q;
  logic          fwd_env_q, fwd_ph_q;

  logic          acc, adv;
  logic [AW-1:0] env_raddr, ph_raddr;
  logic          env_we, ph_we;
  logic [AW-1:0] env_waddr, ph_waddr;
  logic [18:0]   env_wdata;
  logic [15:0]   ph_wdata;

  logic [18:0]   env_cur;
  logic [16:0]   lvl_cur, lvl_n;
  stage_t        stg_cur, stg_n;
  logic [15:0]   ph_cur, ph_new;
  logic          shared_adv, own_adv, upd;
  logic [17:0]   att_sum;
  logic signed [18:0] dec_diff, rel_diff;

  assign in_stall_o = clr_q | (s1_v_q & ~ready_i);
  assign acc        = in_valid_i & ~in_stall_o;
  assign adv        = s1_v_q & ready_i;

  assign env_raddr = AW'(partial_index_i);
  assign ph_raddr  = cfg_i.per_partial ? env_raddr : '0;

  // S1: current values, forwarded when the previous request wrote the same entry
  assign env_cur = fwd_env_q ? fwd_env_data_q : env_rd_q;
  assign ph_cur  = fwd_ph_q ? fwd_ph_data_q : ph_rd_q;
  assign lvl_cur = env_cur[18:2];
  assign stg_cur = all_rel_q ? STG_RELEASE : stage_t'(env_cur[1:0]);
  assign ph_new  = ph_cur + cfg_i.phase_step;

  assign shared_adv = s1_any_q & s1_start_q & ~cfg_i.per_partial & (cfg_i.lfo_depth != '0);
  assign upd        = s1_any_q & s1_inrange_q & s1_active_q;
  assign own_adv    = upd & cfg_i.per_partial;

  always_comb begin
    att_sum  = {1'b0, lvl_cur} + {1'b0, cfg_i.attack_step};
    dec_diff = $signed({2'b00, lvl_cur}) - $signed({2'b00, cfg_i.decay_step});
    rel_diff = $signed({2'b00, lvl_cur}) - $signed({2'b00, cfg_i.rel_step});
    lvl_n    = lvl_cur;
    stg_n    = stg_cur;
    case (stg_cur)
      STG_ATTACK: begin
        if (att_sum >= {1'b0, ONE_Q16}) begin
          lvl_n = ONE_Q16;
          stg_n = STG_DECAY;
        end else begin
          lvl_n = att_sum[16:0];
        end
      end
      STG_DECAY: begin
        if (dec_diff <= $signed({2'b00, cfg_i.sustain_level})) begin
          lvl_n = (cfg_i.sustain_level > ONE_Q16) ? ONE_Q16 : cfg_i.sustain_level;
          stg_n = STG_SUSTAIN;
        end else begin
          lvl_n = dec_diff[16:0];
        end
      end
      STG_SUSTAIN: begin
        lvl_n = lvl_cur;
      end
      default: begin
        lvl_n = (rel_diff < 0) ? '0 : rel_diff[16:0];
      end
    endcase
  end

  // write ports: clearing sweep after reset, otherwise the S1 write-back
  always_comb begin
    env_we    = clr_q | (adv & s1_any_q & s1_inrange_q);
    env_waddr = clr_q ? clr_cnt_q : s1_addr_q;
    env_wdata = '0;
    if (!clr_q) begin
      env_wdata = s1_active_q ? {lvl_n, stg_n} : {lvl_cur, STG_RELEASE};
    end
    ph_we    = clr_q | (adv & (shared_adv | own_adv));
    ph_waddr = clr_q ? clr_cnt_q : (cfg_i.per_partial ? s1_addr_q : '0);
    ph_wdata = clr_q ? '0 : ph_new;
  end

  always_ff @(posedge clk_i) begin
    if (env_we) begin
      env_mem[env_waddr] <= env_wdata;
    end
    if (acc) begin
      env_rd_q <= env_mem[env_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ph_we) begin
      ph_mem[ph_waddr] <= ph_wdata;
    end
    if (acc) begin
      ph_rd_q <= ph_mem[ph_raddr];
    end
  end

  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (clr_cnt_q == AW'(PARTIALS - 1)) begin
        clr_d = 1'b0;
      end
    end
    all_rel_d = all_rel_q | (adv & ~s1_any_q);
    s1_v_d    = acc | (s1_v_q & ~ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      all_rel_q <= 1'b0;
      s1_v_q    <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      all_rel_q <= all_rel_d;
      s1_v_q    <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_addr_q      <= env_raddr;
      s1_active_q    <= is_active_i;
      s1_amp_q       <= amplitude_in_i;
      s1_start_q     <= block_start_i;
      s1_any_q       <= block_any_active_i;
      s1_inrange_q   <= ({26'd0, partial_index_i} < 32'(PARTIALS));
      fwd_env_q      <= env_we & (env_waddr == env_raddr);
      fwd_env_data_q <= env_wdata;
      fwd_ph_q       <= ph_we & (ph_waddr == ph_raddr);
      fwd_ph_data_q  <= ph_wdata;
    end
  end

  always_comb begin
    item_o.valid  = s1_v_q;
    item_o.amp    = s1_amp_q;
    item_o.lvl    = upd ? lvl_n : (s1_inrange_q ? lvl_cur : '0);
    item_o.stage  = upd ? stg_n : STG_RELEASE;
    item_o.mod_en = upd & (cfg_i.lfo_depth != '0);
    item_o.phase  = (shared_adv | cfg_i.per_partial) ? ph_new : ph_cur;
  end

endmodule

[rtl/plm_mod.sv]
// Modulation pipeline: sine lookup, depth and envelope products, gain
// factor, amplitude scaling and output register. Uses plm_pkg, plm_sine_rom.
module plm_mod
  import plm_pkg::*;
#(
  parameter int SINE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cfg_t        cfg_i,
  input  item_t       item_i,
  output logic        ready_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] amplitude_out_o,
  output logic [16:0] envelope_level_o,
  output logic [1:0]  envelope_stage_o
);

  typedef struct packed {
    logic [15:0] amp;
    logic [16:0] lvl;
    stage_t      stage;
    logic        mod_en;
  } pl_t;

  logic [4:0] v_q, v_d, mov;
  logic       ov_q, ov_d;
  logic       load;

  pl_t         pl_q [5];
  logic        neg3_q, neg4_q;
  logic [30:0] p1_q;
  logic [47:0] p2_q;
  logic [32:0] m_q;
  logic [48:0] prod_q;

  logic        rom_neg;
  logic [14:0] rom_mag;
  logic [32:0] term;
  logic [32:0] m_d;
  logic [49:0] rnd;
  logic [15:0] amp_res;

  logic [15:0] amp_out_q;
  logic [16:0] lvl_out_q;
  stage_t      stg_out_q;

  always_comb begin
    mov[4] = v_q[4] & (~ov_q | ~out_stall_i);
    for (int k = 3; k >= 0; k--) begin
      mov[k] = v_q[k] & (~v_q[k+1] | mov[k+1]);
    end
    ready_o = ~v_q[0] | mov[0];
    load    = item_i.valid & ready_o;
    v_d[0]  = load | (v_q[0] & ~mov[0]);
    for (int k = 1; k < 5; k++) begin
      v_d[k] = mov[k-1] | (v_q[k] & ~mov[k]);
    end
    ov_d = mov[4] | (ov_q & out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      v_q  <= v_d;
      ov_q <= ov_d;
    end
  end

  plm_sine_rom #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_rom (
    .clk_i  (clk_i),
    .en_i   (load),
    .phase_i(item_i.phase),
    .neg_o  (rom_neg),
    .mag_o  (rom_mag)
  );

  // half-up rounding to Q30, then 1 +/- term floored at zero
  always_comb begin
    term = 33'(({1'b0, p2_q} + 49'd32768) >> 16);
    if (neg4_q) begin
      m_d = (term >= 33'h040000000) ? '0 : 33'h040000000 - term;
    end else begin
      m_d = 33'h040000000 + term;
    end
    rnd = {1'b0, prod_q} + 50'h0000020000000;
    if (!pl_q[4].mod_en) begin
      amp_res = pl_q[4].amp;
    end else if (rnd[49:30] > 20'd65535) begin
      amp_res = 16'hffff;
    end else begin
      amp_res = rnd[45:30];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pl_q[0] <= '{amp: item_i.amp, lvl: item_i.lvl, stage: item_i.stage,
                   mod_en: item_i.mod_en};
    end
    if (mov[0]) begin
      pl_q[1] <= pl_q[0];
      p1_q    <= {16'd0, rom_mag} * {15'd0, cfg_i.lfo_depth};
      neg3_q  <= rom_neg;
    end
    if (mov[1]) begin
      pl_q[2] <= pl_q[1];
      p2_q    <= {17'd0, p1_q} * {31'd0, pl_q[1].lvl};
      neg4_q  <= neg3_q;
    end
    if (mov[2]) begin
      pl_q[3] <= pl_q[2];
      m_q     <= m_d;
    end
    if (mov[3]) begin
      pl_q[4] <= pl_q[3];
      prod_q  <= {33'd0, pl_q[3].amp} * {16'd0, m_q};
    end
    if (mov[4]) begin
      amp_out_q <= amp_res;
      lvl_out_q <= pl_q[4].lvl;
      stg_out_q <= pl_q[4].stage;
    end
  end

  assign out_valid_o      = ov_q;
  assign amplitude_out_o  = amp_out_q;
  assign envelope_level_o = lvl_out_q;
  assign envelope_stage_o = stg_out_q;

endmodule

[rtl/partial_adsr_lfo_modulator.sv]
// Top level: configuration registers, envelope/phase state and modulation
// pipeline. Uses plm_pkg, plm_state, plm_mod.
//
// Accepts one partial request per clock while in_stall_o is low, returns one
// result per request, in order, via the state stage, modulation pipeline and
// output register. Envelope and LFO phase live in two memories indexed by
// partial; each request reads its entry when accepted and writes it back as it
// leaves the state stage, with forwarding so that back-to-back requests to the
// same partial see fresh state. A clearing sweep after reset zeroes both
// memories, with in_stall_o high; configuration writes are taken throughout.
module partial_adsr_lfo_modulator
  import plm_pkg::*;
#(
  parameter int PARTIALS     = 64,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [5:0]  partial_index_i,
  input  logic        is_active_i,
  input  logic [15:0] amplitude_in_i,
  input  logic        block_start_i,
  input  logic        block_any_active_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] amplitude_out_o,
  output logic [16:0] envelope_level_o,
  output logic [1:0]  envelope_stage_o
);

  cfg_t  cfg_q, cfg_d;
  item_t item;
  logic  mod_ready;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ATTACK_STEP:   cfg_d.attack_step   = cfg_data_i;
        CFG_DECAY_STEP:    cfg_d.decay_step    = cfg_data_i;
        CFG_RELEASE_STEP:  cfg_d.rel_step      = cfg_data_i;
        CFG_SUSTAIN_LEVEL: cfg_d.sustain_level = cfg_data_i;
        CFG_PHASE_STEP:    cfg_d.phase_step    = cfg_data_i[15:0];
        CFG_LFO_DEPTH:     cfg_d.lfo_depth     = cfg_data_i[15:0];
        CFG_PER_PARTIAL:   cfg_d.per_partial   = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.attack_step   <= ONE_Q16;
      cfg_q.decay_step    <= ONE_Q16;
      cfg_q.rel_step      <= ONE_Q16;
      cfg_q.sustain_level <= ONE_Q16;
      cfg_q.phase_step    <= '0;
      cfg_q.lfo_depth     <= '0;
      cfg_q.per_partial   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  plm_state #(
    .PARTIALS(PARTIALS)
  ) u_state (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .partial_index_i   (partial_index_i),
    .is_active_i       (is_active_i),
    .amplitude_in_i    (amplitude_in_i),
    .block_start_i     (block_start_i),
    .block_any_active_i(block_any_active_i),
    .ready_i           (mod_ready),
    .item_o            (item)
  );

  plm_mod #(
    .SINE_ENTRIES(SINE_ENTRIES)
  ) u_mod (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .item_i          (item),
    .ready_o         (mod_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .amplitude_out_o (amplitude_out_o),
    .envelope_level_o(envelope_level_o),
    .envelope_stage_o(envelope_stage_o)
  );

endmodule

[tb/partial_adsr_lfo_modulator_tb.sv]
// Self-checking bench for partial_adsr_lfo_modulator: envelope and LFO predictor,
// queue-fed request driver, result monitor and random stall on both channels.
// Depends on plm_pkg and the partial_adsr_lfo_modulator RTL.
module partial_adsr_lfo_modulator_tb;
  import plm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPART       = 64;
  localparam int SINE_N      = 1024;
  localparam int LIMIT       = 400000;
  localparam int HOLD_CYCLES = 200;

  typedef struct packed {
    logic [5:0]  idx;
    logic        act;
    logic [15:0] amp;
    logic        bstart;
    logic        any;
    logic        drain;
  } partial_req_t;

  typedef struct packed {
    logic [15:0] amp;
    logic [16:0] lvl;
    stage_t      stage;
  } env_result_t;

  logic        clk_i;
  logic        rst_ni             = 1'b0;
  logic        cfg_we_i           = 1'b0;
  logic [2:0]  cfg_index_i        = '0;
  logic [16:0] cfg_data_i         = '0;
  logic        in_valid_i         = 1'b0;
  logic        in_stall_o;
  logic [5:0]  partial_index_i    = '0;
  logic        is_active_i        = 1'b0;
  logic [15:0] amplitude_in_i     = '0;
  logic        block_start_i      = 1'b0;
  logic        block_any_active_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i        = 1'b0;
  logic [15:0] amplitude_out_o;
  logic [16:0] envelope_level_o;
  logic [1:0]  envelope_stage_o;

  partial_adsr_lfo_modulator uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .partial_index_i, .is_active_i, .amplitude_in_i,
    .block_start_i, .block_any_active_i,
    .out_valid_o, .out_stall_i, .amplitude_out_o, .envelope_level_o, .envelope_stage_o
  );

  // shadow of the block's registers and per-partial state
  cfg_t        shadow_cfg;
  logic [15:0] lfo_phase [NPART];
  logic [16:0] env_level [NPART];
  stage_t      env_stage [NPART];

  partial_req_t pending_reqs[$];
  env_result_t  due_results[$];

  int   cyc_count = 0;
  int   n_in = 0, n_out = 0, n_err = 0;
  int   stage_hits [4];
  logic req_taken = 1'b0;
  bit   idle_allowed = 1'b1;
  bit   hold_req = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0, stall_left = 0, gap_left = 0;
  wire  idle_on = idle_allowed && (cyc_count[8:7] != 2'b00);

  function automatic longint unsigned quarter_wave(longint unsigned x);
    longint unsigned x2, t, s;
    x2 = x * x * 64'd4;
    t = 64'd5026995 - ((x2 * 64'd172272) >> 30);
    t = 64'd85569306 - ((x2 * t) >> 30);
    t = 64'd693598668 - ((x2 * t) >> 30);
    t = 64'd1686629713 - ((x2 * t) >> 30);
    s = (x * t) >> 29;
    return (s > 64'd32767) ? 64'd32767 : s;
  endfunction

  function automatic longint unsigned lfo_sine(logic [15:0] ph, output logic neg);
    longint unsigned slot, p, r, x;
    logic [1:0] quad;
    slot = (64'(ph) * 64'(SINE_N)) >> 16;
    p = (slot * 64'd65536) / 64'(SINE_N);
    quad = p[15:14];
    r = p & 64'h3FFF;
    x = quad[0] ? (64'd16384 - r) : r;
    neg = quad[1];
    return quarter_wave(x);
  endfunction

  function automatic env_result_t predict_partial(partial_req_t rq);
    env_result_t     r;
    longint          lv;
    longint unsigned lvu, s, mag, term, m, ao;
    stage_t          st;
    logic [15:0]     ph;
    logic            neg;
    int              i;
    r.amp = rq.amp;
    r.lvl = env_level[rq.idx];
    r.stage = STG_RELEASE;
    if (!rq.any) begin
      for (i = 0; i < NPART; i++) env_stage[i] = STG_RELEASE;
    end else begin
      if (rq.bstart && !shadow_cfg.per_partial && shadow_cfg.lfo_depth != 16'd0)
        lfo_phase[0] = lfo_phase[0] + shadow_cfg.phase_step;
      if (!rq.act) begin
        env_stage[rq.idx] = STG_RELEASE;
      end else begin
        if (shadow_cfg.per_partial)
          lfo_phase[rq.idx] = lfo_phase[rq.idx] + shadow_cfg.phase_step;
        lv = longint'(env_level[rq.idx]);
        st = env_stage[rq.idx];
        case (st)
          STG_ATTACK: begin
            lv = lv + longint'(shadow_cfg.attack_step);
            if (lv >= 65536) begin
              lv = 65536;
              st = STG_DECAY;
            end
          end
          STG_DECAY: begin
            lv = lv - longint'(shadow_cfg.decay_step);
            if (lv <= longint'(shadow_cfg.sustain_level)) begin
              lv = longint'(shadow_cfg.sustain_level);
              st = STG_SUSTAIN;
            end
          end
          STG_SUSTAIN: ;
          default: lv = lv - longint'(shadow_cfg.rel_step);
        endcase
        if (lv < 0) lv = 0;
        if (lv > 65536) lv = 65536;
        env_level[rq.idx] = 17'(lv);
        env_stage[rq.idx] = st;
        r.lvl = 17'(lv);
        r.stage = st;
        if (shadow_cfg.lfo_depth != 16'd0) begin
          ph = shadow_cfg.per_partial ? lfo_phase[rq.idx] : lfo_phase[0];
          s = lfo_sine(ph, neg);
          lvu = 64'(lv);
          mag = s * 64'(shadow_cfg.lfo_depth) * lvu;
          term = (mag + 64'd32768) >> 16;
          if (neg) m = (term >= 64'h4000_0000) ? 64'd0 : 64'h4000_0000 - term;
          else m = 64'h4000_0000 + term;
          ao = (64'(rq.amp) * m + 64'h2000_0000) >> 30;
          if (ao > 64'd65535) ao = 64'd65535;
          r.amp = 16'(ao);
        end
      end
    end
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc_count <= cyc_count + 1;
    if (cyc_count > LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // request driver
  always @(negedge clk_i) begin : req_driver
    partial_req_t nxt;
    logic give;
    nxt = '0;
    give = 1'b0;
    if (!in_valid_i || req_taken) begin
      if (gap_left != 0) begin
        gap_left--;
      end else if (pending_reqs.size() != 0 &&
                   !(pending_reqs[0].drain && due_results.size() != 0)) begin
        if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(1, 10) - 1;
        end else begin
          nxt = pending_reqs.pop_front();
          give = 1'b1;
        end
      end
      in_valid_i <= give;
      if (give) begin
        partial_index_i    <= nxt.idx;
        is_active_i        <= nxt.act;
        amplitude_in_i     <= nxt.amp;
        block_start_i      <= nxt.bstart;
        block_any_active_i <= nxt.any;
      end
    end
  end

  // result sink stall
  always @(negedge clk_i) begin : result_sink
    if (hold_left != 0) begin
      hold_left--;
    end else if (hold_req && !hold_taken) begin
      hold_left = HOLD_CYCLES;
      hold_taken = 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 10);
    end
    out_stall_i <= (hold_left != 0) || (stall_left != 0);
  end

  // monitor: predicts on each accepted request, checks each accepted result
  always @(posedge clk_i) begin : result_check
    partial_req_t seen;
    env_result_t want;
    req_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      seen.idx    = partial_index_i;
      seen.act    = is_active_i;
      seen.amp    = amplitude_in_i;
      seen.bstart = block_start_i;
      seen.any    = block_any_active_i;
      seen.drain  = 1'b0;
      want = predict_partial(seen);
      due_results.push_back(want);
      stage_hits[want.stage]++;
      n_in++;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (due_results.size() == 0) begin
        $display("%0t: result with none outstanding, amp %0d level %0d stage %0d",
                 $time, amplitude_out_o, envelope_level_o, envelope_stage_o);
        n_err++;
      end else begin
        want = due_results.pop_front();
        if (amplitude_out_o !== want.amp) begin
          $display("%0t: amplitude_out expected %0d got %0d", $time, want.amp,
                   amplitude_out_o);
          n_err++;
        end
        if (envelope_level_o !== want.lvl) begin
          $display("%0t: envelope_level expected %0d got %0d", $time, want.lvl,
                   envelope_level_o);
          n_err++;
        end
        if (envelope_stage_o !== want.stage) begin
          $display("%0t: envelope_stage expected %0d got %0d", $time, want.stage,
                   envelope_stage_o);
          n_err++;
        end
      end
    end
  end

  task automatic write_reg(input logic [2:0] ri, input logic [16:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= ri;
    cfg_data_i  <= val;
    case (ri)
      CFG_ATTACK_STEP:   shadow_cfg.attack_step = val;
      CFG_DECAY_STEP:    shadow_cfg.decay_step = val;
      CFG_RELEASE_STEP:  shadow_cfg.rel_step = val;
      CFG_SUSTAIN_LEVEL: shadow_cfg.sustain_level = val;
      CFG_PHASE_STEP:    shadow_cfg.phase_step = val[15:0];
      CFG_LFO_DEPTH:     shadow_cfg.lfo_depth = val[15:0];
      CFG_PER_PARTIAL:   shadow_cfg.per_partial = val[0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic push_req(input logic [5:0] idx, input logic act, input logic [15:0] amp,
                          input logic bstart, input logic any);
    partial_req_t rq;
    rq.idx = idx;
    rq.act = act;
    rq.amp = amp;
    rq.bstart = bstart;
    rq.any = any;
    rq.drain = 1'b0;
    pending_reqs.push_back(rq);
  endtask

  // blocks of requests on partials base..base+7; a quiet tail drives block_any_active low
  task automatic queue_blocks(input int base, input int count, input bit quiet_tail);
    partial_req_t rq;
    int n, len, k, pick;
    logic blk_any;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 16) : $urandom_range(1, 6);
      blk_any = !(quiet_tail && n >= count - 20);
      for (k = 0; k < len; k++) begin
        rq.idx = 6'(base + $urandom_range(0, 7));
        rq.act = ($urandom_range(0, 39) != 0) || ($urandom_range(0, 1) == 0 && !blk_any);
        pick = $urandom_range(0, 15);
        rq.amp = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        rq.bstart = (k == 0) ^ ($urandom_range(0, 29) == 0);
        rq.any = blk_any;
        rq.drain = 1'b0;
        pending_reqs.push_back(rq);
        n++;
      end
    end
  endtask

  task automatic wait_drained();
    while (!(pending_reqs.size() == 0 && due_results.size() == 0 && !in_valid_i))
      @(posedge clk_i);
  endtask

  task automatic random_settings(input logic per_partial);
    write_reg(CFG_ATTACK_STEP, 17'($urandom_range(2000, 40000)));
    write_reg(CFG_DECAY_STEP, 17'($urandom_range(500, 30000)));
    write_reg(CFG_RELEASE_STEP, 17'($urandom_range(500, 30000)));
    write_reg(CFG_SUSTAIN_LEVEL, ($urandom_range(0, 3) == 0) ? ONE_Q16 :
                                 17'($urandom_range(0, 65535)));
    write_reg(CFG_PHASE_STEP, 17'($urandom_range(0, 65535)));
    write_reg(CFG_LFO_DEPTH, ($urandom_range(0, 4) == 0) ? 17'd0 :
                             17'($urandom_range(1, 32768)));
    write_reg(CFG_PER_PARTIAL, {16'd0, per_partial});
    end_writes();
  endtask

  initial begin : run_sequence
    int i, p;
    shadow_cfg.attack_step   = ONE_Q16;
    shadow_cfg.decay_step    = ONE_Q16;
    shadow_cfg.rel_step      = ONE_Q16;
    shadow_cfg.sustain_level = ONE_Q16;
    shadow_cfg.phase_step    = '0;
    shadow_cfg.lfo_depth     = '0;
    shadow_cfg.per_partial   = 1'b0;
    for (i = 0; i < NPART; i++) begin
      lfo_phase[i] = '0;
      env_level[i] = '0;
      env_stage[i] = STG_ATTACK;
    end
    for (i = 0; i < 4; i++) stage_hits[i] = 0;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: full steps, no LFO; walk partial 0 through every stage
    push_req(6'd0, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    push_req(6'd0, 1'b1, 16'h0000, 1'b0, 1'b1);
    push_req(6'd0, 1'b1, 16'h8000, 1'b1, 1'b1);
    push_req(6'd0, 1'b0, 16'h1234, 1'b0, 1'b1);
    push_req(6'd0, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    push_req(6'd0, 1'b1, 16'h7FFF, 1'b0, 1'b1);
    push_req(6'd7, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    push_req(6'd7, 1'b1, 16'h0001, 1'b0, 1'b1);
    wait_drained();

    // full depth, shared phase stepping a quarter cycle, sustain at zero
    write_reg(CFG_ATTACK_STEP, ONE_Q16);
    write_reg(CFG_DECAY_STEP, ONE_Q16);
    write_reg(CFG_RELEASE_STEP, ONE_Q16);
    write_reg(CFG_SUSTAIN_LEVEL, 17'd0);
    write_reg(CFG_PHASE_STEP, 17'd16384);
    write_reg(CFG_LFO_DEPTH, 17'd32768);
    write_reg(CFG_PER_PARTIAL, 17'd0);
    end_writes();
    push_req(6'd1, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    push_req(6'd2, 1'b0, 16'hFFFF, 1'b1, 1'b1);
    push_req(6'd1, 1'b1, 16'hFFFF, 1'b0, 1'b1);
    push_req(6'd3, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    push_req(6'd4, 1'b1, 16'h8000, 1'b1, 1'b1);
    push_req(6'd5, 1'b1, 16'hFFFF, 1'b1, 1'b1);
    push_req(6'd6, 1'b0, 16'h5555, 1'b0, 1'b1);
    queue_blocks(8, 300, 1'b0);
    wait_drained();

    // zero steps, own phase per partial, maximum phase step, minimal depth
    write_reg(CFG_ATTACK_STEP, 17'd0);
    write_reg(CFG_DECAY_STEP, 17'd0);
    write_reg(CFG_RELEASE_STEP, 17'd0);
    write_reg(CFG_SUSTAIN_LEVEL, ONE_Q16);
    write_reg(CFG_PHASE_STEP, 17'd65535);
    write_reg(CFG_LFO_DEPTH, 17'd1);
    write_reg(CFG_PER_PARTIAL, 17'd1);
    end_writes();
    queue_blocks(16, 100, 1'b0);
    wait_drained();

    for (p = 3; p <= 7; p++) begin
      random_settings(logic'(p % 2 == 0) ^ logic'($urandom_range(0, 3) == 0));
      if (p == 7) idle_allowed = 1'b0;
      queue_blocks(8 * p, 300, p == 7);
      if (p == 3) hold_req = 1'b1;
      if (p == 4) pending_reqs[pending_reqs.size() / 2].drain = 1'b1;
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("Checked %0d results for %0d requests across eight register settings, %0d errors",
             n_out, n_in, n_err);
    $display("Stages predicted: attack %0d, decay %0d, sustain %0d, release %0d",
             stage_hits[0], stage_hits[1], stage_hits[2], stage_hits[3]);
    if (n_err == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
